// ===== src/vt4_pkg.sv =====
package vt4_pkg;

  // Geometry and number format
  localparam int ROWS      = 4;
  localparam int COLS      = 4;
  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 12;
  localparam int ROW_W     = COLS * DATA_W;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SHIFT_W   = SUM_W - FRAC_BITS;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_0 = 3'd0,
    REG_ROW_1 = 3'd1,
    REG_ROW_2 = 3'd2,
    REG_ROW_3 = 3'd3
  } cfg_reg_t;

  // Identity matrix after reset
  localparam logic [ROW_W-1:0] ROW_0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_2_RESET = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW_3_RESET = 64'h1000_0000_0000_0000;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic [ROW_W-1:0]         row_t;

  // Handshake between pipeline stages
  typedef struct packed {
    logic valid;
  } stage_fwd_t;

  typedef struct packed {
    logic ready;
  } stage_bwd_t;

endpackage

// ===== src/vt4_mul_stage.sv =====
module vt4_mul_stage (
  input  logic                clk,
  input  logic                rst,
  input  vt4_pkg::stage_fwd_t up_fwd,
  output vt4_pkg::stage_bwd_t up_bwd,
  input  vt4_pkg::coef_t      vec [vt4_pkg::COLS],
  input  vt4_pkg::row_t       matrix [vt4_pkg::ROWS],
  output vt4_pkg::stage_fwd_t dn_fwd,
  input  vt4_pkg::stage_bwd_t dn_bwd,
  output vt4_pkg::prod_t      prod [vt4_pkg::ROWS][vt4_pkg::COLS]
);
  import vt4_pkg::*;

  logic advance;

  // Take a new item whenever this stage is empty or drains downstream
  assign advance      = !dn_fwd.valid || dn_bwd.ready;
  assign up_bwd.ready = advance;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_fwd.valid <= 1'b0;
    end else if (advance) begin
      dn_fwd.valid <= up_fwd.valid;
    end
  end

  // One registered multiplier per matrix coefficient
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          prod[r][c] <= $signed(matrix[r][c*DATA_W +: DATA_W]) * vec[c];
        end
      end
    end
  end

endmodule

// ===== src/vt4_pair_stage.sv =====
module vt4_pair_stage (
  input  logic                clk,
  input  logic                rst,
  input  vt4_pkg::stage_fwd_t up_fwd,
  output vt4_pkg::stage_bwd_t up_bwd,
  input  vt4_pkg::prod_t      prod [vt4_pkg::ROWS][vt4_pkg::COLS],
  output vt4_pkg::stage_fwd_t dn_fwd,
  input  vt4_pkg::stage_bwd_t dn_bwd,
  output vt4_pkg::pair_t      pair [vt4_pkg::ROWS][2]
);
  import vt4_pkg::*;

  logic advance;

  assign advance      = !dn_fwd.valid || dn_bwd.ready;
  assign up_bwd.ready = advance;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_fwd.valid <= 1'b0;
    end else if (advance) begin
      dn_fwd.valid <= up_fwd.valid;
    end
  end

  // Add products in pairs: (w + x) and (y + z) for each row
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < ROWS; r++) begin
        pair[r][0] <= PAIR_W'(prod[r][0]) + PAIR_W'(prod[r][1]);
        pair[r][1] <= PAIR_W'(prod[r][2]) + PAIR_W'(prod[r][3]);
      end
    end
  end

endmodule

// ===== src/vt4_out_stage.sv =====
module vt4_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  vt4_pkg::stage_fwd_t up_fwd,
  output vt4_pkg::stage_bwd_t up_bwd,
  input  vt4_pkg::pair_t      pair [vt4_pkg::ROWS][2],
  output logic                out_valid,
  input  logic                out_ready,
  output vt4_pkg::coef_t      result [vt4_pkg::ROWS],
  output logic                clip
);
  import vt4_pkg::*;

  logic                      advance;
  logic signed [SUM_W-1:0]   sum     [ROWS];
  logic signed [SHIFT_W-1:0] shifted [ROWS];
  coef_t                     sat_val [ROWS];
  logic [ROWS-1:0]           sat_hit;

  assign advance      = !out_valid || out_ready;
  assign up_bwd.ready = advance;

  // Final add, floor shift, saturate
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      sum[r]     = SUM_W'(pair[r][0]) + SUM_W'(pair[r][1]);
      shifted[r] = SHIFT_W'(sum[r] >>> FRAC_BITS);
      if (shifted[r] > SHIFT_W'(SAT_MAX)) begin
        sat_val[r] = SAT_MAX;
        sat_hit[r] = 1'b1;
      end else if (shifted[r] < SHIFT_W'(SAT_MIN)) begin
        sat_val[r] = SAT_MIN;
        sat_hit[r] = 1'b1;
      end else begin
        sat_val[r] = DATA_W'(shifted[r]);
        sat_hit[r] = 1'b0;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= up_fwd.valid;
    end
  end

  // Output register; holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < ROWS; r++) begin
        result[r] <= sat_val[r];
      end
      clip <= |sat_hit;
    end
  end

endmodule

// ===== src/vector_transform_4x4_top.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_ready    in_w, in_x, in_y, in_z (signed Q4.12)
// output    out_valid / out_ready  out_w, out_x, out_y, out_z (signed Q4.12), clipped
// config    cfg_write              cfg_index, cfg_data (matrix rows 0..3)
//
// One vector per clock while the output is not stalled.
// Stages: 16 registered 16x16 multipliers, pairwise adds, final add with floor
// shift and saturation into the output register.
// Reset loads the identity matrix and empties the pipeline; no clearing pass.
// A stall at the output backs up stage by stage; empty stages keep filling.
module vector_transform_4x4_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [vt4_pkg::DATA_W-1:0]    in_w,
  input  logic signed [vt4_pkg::DATA_W-1:0]    in_x,
  input  logic signed [vt4_pkg::DATA_W-1:0]    in_y,
  input  logic signed [vt4_pkg::DATA_W-1:0]    in_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [vt4_pkg::DATA_W-1:0]    out_w,
  output logic signed [vt4_pkg::DATA_W-1:0]    out_x,
  output logic signed [vt4_pkg::DATA_W-1:0]    out_y,
  output logic signed [vt4_pkg::DATA_W-1:0]    out_z,
  output logic                                 clipped,
  input  logic                                 cfg_write,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vt4_pkg::ROW_W-1:0]            cfg_data
);
  import vt4_pkg::*;

  row_t       matrix [ROWS];
  coef_t      vec    [COLS];
  prod_t      prod   [ROWS][COLS];
  pair_t      pair   [ROWS][2];
  coef_t      result [ROWS];
  stage_fwd_t in_fwd, mul_fwd, pair_fwd;
  stage_bwd_t in_bwd, mul_bwd, pair_bwd;

  // Matrix rows; out-of-range indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix[0] <= ROW_0_RESET;
      matrix[1] <= ROW_1_RESET;
      matrix[2] <= ROW_2_RESET;
      matrix[3] <= ROW_3_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_0: matrix[0] <= cfg_data;
        REG_ROW_1: matrix[1] <= cfg_data;
        REG_ROW_2: matrix[2] <= cfg_data;
        REG_ROW_3: matrix[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign vec[0]       = in_w;
  assign vec[1]       = in_x;
  assign vec[2]       = in_y;
  assign vec[3]       = in_z;
  assign in_fwd.valid = in_valid;
  assign in_ready     = in_bwd.ready;

  vt4_mul_stage u_mul (
    .clk    (clk),
    .rst    (rst),
    .up_fwd (in_fwd),
    .up_bwd (in_bwd),
    .vec    (vec),
    .matrix (matrix),
    .dn_fwd (mul_fwd),
    .dn_bwd (mul_bwd),
    .prod   (prod)
  );

  vt4_pair_stage u_pair (
    .clk    (clk),
    .rst    (rst),
    .up_fwd (mul_fwd),
    .up_bwd (mul_bwd),
    .prod   (prod),
    .dn_fwd (pair_fwd),
    .dn_bwd (pair_bwd),
    .pair   (pair)
  );

  vt4_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .up_fwd    (pair_fwd),
    .up_bwd    (pair_bwd),
    .pair      (pair),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .clip      (clipped)
  );

  assign out_w = result[0];
  assign out_x = result[1];
  assign out_y = result[2];
  assign out_z = result[3];

endmodule

// ===== src/vt4_checker.sv =====
module vt4_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [vt4_pkg::DATA_W-1:0] out_w,
  input logic signed [vt4_pkg::DATA_W-1:0] out_x,
  input logic signed [vt4_pkg::DATA_W-1:0] out_y,
  input logic signed [vt4_pkg::DATA_W-1:0] out_z,
  input logic                              clipped
);
  import vt4_pkg::*;

  // Stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_w) && $stable(out_x)
      && $stable(out_y) && $stable(out_z) && $stable(clipped))
    else $error("result changed while stalled");

  // Pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // An empty output register means every stage can take an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // A clipped result has at least one component at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      (out_w == SAT_MAX) || (out_w == SAT_MIN) || (out_x == SAT_MAX) ||
      (out_x == SAT_MIN) || (out_y == SAT_MAX) || (out_y == SAT_MIN) ||
      (out_z == SAT_MAX) || (out_z == SAT_MIN))
    else $error("clipped set with no saturated component");

endmodule

bind vector_transform_4x4_top vt4_checker u_vt4_checker (.*);

// ===== sim/vector_transform_4x4_top_tb.sv =====
module vector_transform_4x4_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vt4_pkg::*;

  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 100;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_LIMIT   = 2000;

  typedef struct {
    coef_t w;
    coef_t x;
    coef_t y;
    coef_t z;
    logic  clip;
  } vector_result_t;

  // Matrix copy plus queue of transformed vectors still owed by the block
  class transform_scoreboard;
    row_t           matrix [ROWS];
    vector_result_t predicted_outputs [$];
    int             errors;

    function new();
      matrix[REG_ROW_0] = ROW_0_RESET;
      matrix[REG_ROW_1] = ROW_1_RESET;
      matrix[REG_ROW_2] = ROW_2_RESET;
      matrix[REG_ROW_3] = ROW_3_RESET;
      errors = 0;
    endfunction

    // Writes to indexes past the last row are dropped by the block
    function void set_row(int idx, row_t value);
      if (idx < ROWS) begin
        matrix[idx] = value;
      end
    endfunction

    function int pending();
      return predicted_outputs.size();
    endfunction

    // Multiply the vector by the matrix, floor shift, saturate
    function void note_vector(coef_t w, coef_t x, coef_t y, coef_t z);
      coef_t          vin [COLS];
      coef_t          comp [ROWS];
      longint         acc;
      longint         shifted;
      vector_result_t res;
      vin = '{w, x, y, z};
      res.clip = 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        acc = 0;
        for (int c = 0; c < COLS; c++) begin
          acc += longint'(coef_t'(matrix[r][DATA_W*c +: DATA_W])) * longint'(vin[c]);
        end
        shifted = acc >>> FRAC_BITS;
        if (shifted > longint'(SAT_MAX)) begin
          comp[r] = SAT_MAX;
          res.clip = 1'b1;
        end else if (shifted < longint'(SAT_MIN)) begin
          comp[r] = SAT_MIN;
          res.clip = 1'b1;
        end else begin
          comp[r] = coef_t'(shifted);
        end
      end
      res.w = comp[0];
      res.x = comp[1];
      res.y = comp[2];
      res.z = comp[3];
      predicted_outputs.push_back(res);
    endfunction

    function void compare_field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_vector(coef_t w, coef_t x, coef_t y, coef_t z, logic clip);
      vector_result_t exp_res;
      if (predicted_outputs.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual %0d %0d %0d %0d clip %0d",
                 $time, w, x, y, z, clip);
        errors++;
        return;
      end
      exp_res = predicted_outputs.pop_front();
      compare_field("out_w", exp_res.w, w);
      compare_field("out_x", exp_res.x, x);
      compare_field("out_y", exp_res.y, y);
      compare_field("out_z", exp_res.z, z);
      compare_field("clipped", exp_res.clip, clip);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  coef_t                in_w = '0;
  coef_t                in_x = '0;
  coef_t                in_y = '0;
  coef_t                in_z = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  coef_t                out_w;
  coef_t                out_x;
  coef_t                out_y;
  coef_t                out_z;
  logic                 clipped;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  row_t                 cfg_data = '0;

  transform_scoreboard sb = new();
  bit                  hold_off_req = 1'b0;
  int                  idle_cycles = 0;

  vector_transform_4x4_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_w      (in_w),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_w     (out_w),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .clipped   (clipped),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Record accepted input items and check accepted results
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sb.note_vector(in_w, in_x, in_y, in_z);
    end
    if (!rst && out_valid && out_ready) begin
      sb.check_vector(out_w, out_x, out_y, out_z, clipped);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: segments of steady, random or sparse ready, plus long hold-offs on request
  initial begin : receiver
    int seg_len;
    int mode;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        seg_len = $urandom_range(8, 64);
        mode = $urandom_range(0, 2);
        repeat (seg_len) begin
          case (mode)
            0: begin
              out_ready <= 1'b1;
            end
            1: begin
              out_ready <= $urandom_range(0, 1);
            end
            default: begin
              out_ready <= ($urandom_range(0, 3) == 0);
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Offer one vector and hold it until accepted
  task automatic send_vector(coef_t w, coef_t x, coef_t y, coef_t z);
    in_valid <= 1'b1;
    in_w <= w;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending and wait for every owed result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    // let the last accepted item reach the scoreboard first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four rows back to back, optionally followed by a write past the last row
  task automatic load_matrix(row_t rows [ROWS], bit stray);
    for (int i = 0; i < ROWS; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= rows[i];
      @(posedge clk);
      sb.set_row(i, rows[i]);
    end
    if (stray) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(ROWS + $urandom_range(0, 3));
      cfg_data <= {$urandom, $urandom};
      @(posedge clk);
      sb.set_row(int'(cfg_index), cfg_data);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic row_t splat(coef_t c);
    return {COLS{c}};
  endfunction

  function automatic coef_t rand_component();
    case ($urandom_range(0, 9))
      6: return SAT_MAX;
      7: return SAT_MIN;
      8: return coef_t'($urandom_range(0, 32) - 16);
      9: return coef_t'($urandom_range(0, 8192) - 4096);
      default: return coef_t'($urandom);
    endcase
  endfunction

  function automatic row_t rand_row();
    row_t row;
    case ($urandom_range(0, 7))
      0, 1: begin
        row = {$urandom, $urandom};
      end
      2: begin
        row = splat(SAT_MAX);
      end
      3: begin
        row = splat(SAT_MIN);
      end
      4: begin
        row = ROW_0_RESET << (DATA_W * $urandom_range(0, COLS - 1));
      end
      default: begin
        for (int c = 0; c < COLS; c++) begin
          row[DATA_W*c +: DATA_W] = coef_t'($urandom_range(0, 8192) - 4096);
        end
      end
    endcase
    return row;
  endfunction

  task automatic directed_items();
    row_t rows [ROWS];
    // identity from reset: exact pass-through at the range ends
    send_vector(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_vector(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    send_vector(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    send_vector(SAT_MAX, SAT_MIN, 16'sd1, -16'sd1);
    send_vector(16'sh5a5a, -16'sh5a5b, 16'sh1234, -16'sh0fed);
    drain();
    // largest positive coefficients: clip high and low, floor of small negatives
    rows = '{default: splat(SAT_MAX)};
    load_matrix(rows, 1'b0);
    send_vector(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    send_vector(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    send_vector(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_vector(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    drain();
    // most negative coefficients: products of the two minimums overflow upward
    rows = '{default: splat(SAT_MIN)};
    load_matrix(rows, 1'b0);
    send_vector(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    send_vector(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    send_vector(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX);
    drain();
    // tiny coefficients: floor rounding around zero, with an ignored stray write
    rows = '{default: splat(16'sd1)};
    load_matrix(rows, 1'b1);
    send_vector(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_vector(-16'sd4096, 16'sd0, 16'sd0, 16'sd0);
    send_vector(-16'sd4097, 16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd4095, 16'sd1, 16'sd0, 16'sd0);
    drain();
  endtask

  task automatic random_phase(int phase);
    row_t rows [ROWS];
    int   sent;
    int   burst;
    int   gap;
    for (int r = 0; r < ROWS; r++) begin
      rows[r] = rand_row();
    end
    load_matrix(rows, $urandom_range(0, 2) == 0);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
        send_vector(rand_component(), rand_component(), rand_component(), rand_component());
        sent++;
        // block the output for a long stretch while items keep coming
        if (sent == 20 && (phase == 2 || phase == 5)) begin
          hold_off_req = 1'b1;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pause_sender(gap);
      end
    end
    drain();
  endtask

  initial begin : main
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      random_phase(p);
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
